// ===== rtl/mhad_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhad_pkg
// shared types and constants of the median heat alarm detector
// ----------------------------------------------------------------------------
package mhad_pkg;

	localparam int FLOORS_DEF      = 5;
	localparam int WINDOW_DEF      = 30;
	localparam int MEDIAN_TAPS_DEF = 5;

	localparam int QUEUE_DEPTH  = 4;
	localparam int RESULT_DEPTH = 4;
	localparam int RESULT_LW    = $clog2(RESULT_DEPTH + 1);

	localparam logic signed [15:0] HOT_THRESHOLD_RST = 16'sd58;
	localparam logic [4:0]         HOT_COUNT_RST     = 5'd27;
	localparam logic [15:0]        RISE_THRESHOLD_RST = 16'd8;

	typedef struct packed {
		logic signed [15:0] hot_threshold;
		logic [4:0]         hot_count_needed;
		logic [15:0]        rise_threshold;
	} cfg_t;

	// one accepted reading after classification
	typedef struct packed {
		logic               floor_ok;
		logic [2:0]         floor;
		logic signed [15:0] temperature;
	} front_item_t;

	typedef struct packed {
		logic signed [15:0] median_value;
		logic               median_valid;
		logic [2:0]         alarm_floor;
		logic               alarm;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/mhad_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhad_fifo
// small register queue with a fill level, used between the stages
// ----------------------------------------------------------------------------
module mhad_fifo import mhad_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push_valid,
	output logic                              push_ready,
	input  wire logic [WIDTH-1:0]             push_data,
	output logic                              pop_valid,
	input  wire logic                         pop_ready,
	output logic [WIDTH-1:0]                  pop_data,
	output logic [$clog2(DEPTH + 1)-1:0]      level
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [LW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != LW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = store_q[rd_q];
	assign level      = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mhad_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhad_front
// accepts readings, flags the floor range and queues them for the back end
// ----------------------------------------------------------------------------
module mhad_front import mhad_pkg::*; #(
	parameter int FLOORS = FLOORS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] temperature
	input  wire logic [2:0]  s_axis_tuser,   // [2:0] floor
	output logic             item_valid,
	input  wire logic        item_ready,
	output front_item_t      item_data
);

	front_item_t in_item;
	logic [$bits(front_item_t)-1:0] q_dout;

	always_comb begin
		in_item.floor_ok    = (32'(s_axis_tuser) < FLOORS);
		in_item.floor       = s_axis_tuser;
		in_item.temperature = s_axis_tdata;
	end

	mhad_fifo #(
		.WIDTH ($bits(front_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_axis_tvalid),
		.push_ready (s_axis_tready),
		.push_data  (in_item),
		.pop_valid  (item_valid),
		.pop_ready  (item_ready),
		.pop_data   (q_dout),
		.level      ()
	);

	assign item_data = front_item_t'(q_dout);

endmodule
`default_nettype wire

// ===== rtl/mhad_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhad_back
// per-floor raw rings, median, smoothed window memory, hot count and alarm
// ----------------------------------------------------------------------------
module mhad_back import mhad_pkg::*; #(
	parameter int FLOORS      = FLOORS_DEF,
	parameter int WINDOW      = WINDOW_DEF,
	parameter int MEDIAN_TAPS = MEDIAN_TAPS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_t                 cfg,
	input  wire logic                 recount,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire front_item_t          in_item,
	output logic                      res_valid,
	output result_t                   res_item,
	input  wire logic [RESULT_LW-1:0] res_level
);

	localparam int N     = MEDIAN_TAPS;
	localparam int FW    = (FLOORS > 1) ? $clog2(FLOORS) : 1;
	localparam int SW    = $clog2(WINDOW);
	localparam int CW    = $clog2(WINDOW + 1);
	localparam int CMPW  = (CW > 5) ? CW : 5;
	localparam int RSW   = $clog2(N);
	localparam int RFW   = $clog2(N + 1);
	localparam int RW    = $clog2(N);
	localparam int MEM_D = FLOORS * WINDOW;
	localparam int AW    = (MEM_D > 1) ? $clog2(MEM_D) : 1;
	localparam int MID   = N / 2;
	localparam bit EVEN  = ((N % 2) == 0);

	typedef struct packed {
		logic               proceed;
		logic               push;
		logic [FW-1:0]      fidx;
		logic [2:0]         floor;
		logic [SW-1:0]      slot;
		logic               rise_en;
		logic [N-1:0][15:0] taps;
	} s1_t;

	typedef struct packed {
		logic               proceed;
		logic               push;
		logic [FW-1:0]      fidx;
		logic [2:0]         floor;
		logic [SW-1:0]      slot;
		logic               rise_en;
		logic signed [15:0] med;
		logic signed [15:0] oldest;
	} s2_t;

	// per-floor state and the alarm latch
	logic [N-1:0][15:0] raw_q      [FLOORS];
	logic [RFW-1:0]     raw_fill_q [FLOORS];
	logic [RSW-1:0]     raw_slot_q [FLOORS];
	logic [CW-1:0]      sm_fill_q  [FLOORS];
	logic [SW-1:0]      sm_slot_q  [FLOORS];
	logic [WINDOW-1:0]  hot_bits_q [FLOORS];
	logic [CW-1:0]      hot_cnt_q  [FLOORS];
	logic               alarm_q;
	logic [2:0]         alarm_src_q;

	// smoothed window memory
	logic [15:0]        win_mem [MEM_D];
	logic [15:0]        rdata_q;
	logic               fwd_q;
	logic [15:0]        fwd_data_q;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic               we;

	// threshold recount sweep
	logic               sw_act_q;
	logic [FW-1:0]      sw_f_q;
	logic [SW-1:0]      sw_k_q;
	logic               sw_v_s1;
	logic [FW-1:0]      sw_f_s1;
	logic [SW-1:0]      sw_k_s1;
	logic               sw_hot;
	logic               busy;

	// issue stage
	logic               issue;
	logic               proceed0;
	logic [FW-1:0]      fidx0;
	logic [RSW-1:0]     rslot0;
	logic [RFW-1:0]     rfill0;
	logic [N-1:0][15:0] taps0;
	logic               push0;
	logic [SW-1:0]      sslot0;
	logic [SW-1:0]      snext0;
	logic [CW-1:0]      sfill0;
	logic               rise0;
	logic [AW-1:0]      e0_addr;

	// median stage
	logic               v_s1;
	s1_t                s1;
	logic [RW-1:0]      rank [N];
	logic [15:0]        med_lo;
	logic [15:0]        med_hi;
	logic signed [16:0] med_sum;
	logic signed [16:0] med_adj;
	logic [15:0]        med1;

	// update stage
	logic               v_s2;
	s2_t                s2;
	logic               do_push;
	logic               new_hot;
	logic               old_hot;
	logic [CW-1:0]      cnt_new;
	logic signed [16:0] diff;
	logic               rise_hit;
	logic               cnt_hit;
	logic               trip;

	assign busy     = recount || sw_act_q || sw_v_s1;
	// no issue while the median stage holds an item keeps the window write ahead of the next read
	assign issue    = in_valid && !busy && !v_s1
	                  && ((32'(res_level) + 32'(v_s2)) < RESULT_DEPTH);
	assign in_ready = issue;

	// ---------------- issue stage ----------------
	always_comb begin
		fidx0    = FW'(in_item.floor);
		proceed0 = in_item.floor_ok && !alarm_q;
		rslot0   = raw_slot_q[fidx0];
		rfill0   = raw_fill_q[fidx0];
		taps0    = raw_q[fidx0];
		taps0[rslot0] = in_item.temperature;
		push0    = (rfill0 >= RFW'(N - 1));
		sslot0   = sm_slot_q[fidx0];
		snext0   = (sslot0 == SW'(WINDOW - 1)) ? '0 : sslot0 + 1'b1;
		sfill0   = sm_fill_q[fidx0];
		rise0    = (sfill0 >= CW'(WINDOW - 1));
		e0_addr  = AW'(32'(fidx0) * 32'(WINDOW) + 32'(snext0));
	end

	assign raddr = sw_act_q ? AW'(32'(sw_f_q) * 32'(WINDOW) + 32'(sw_k_q)) : e0_addr;

	// ---------------- median stage ----------------
	always_comb begin
		for (int i = 0; i < N; i++) begin
			rank[i] = '0;
			for (int j = 0; j < N; j++) begin
				if (j != i) begin
					if (($signed(s1.taps[j]) < $signed(s1.taps[i]))
					    || ((s1.taps[j] == s1.taps[i]) && (j < i))) begin
						rank[i] = rank[i] + 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		med_lo = '0;
		med_hi = '0;
		for (int i = 0; i < N; i++) begin
			if (rank[i] == RW'(MID)) begin
				med_hi = s1.taps[i];
			end
			if (rank[i] == RW'(MID - 1)) begin
				med_lo = s1.taps[i];
			end
		end
		med_sum = {med_lo[15], med_lo} + {med_hi[15], med_hi};
		// mean of the middle pair, rounded toward zero
		med_adj = med_sum + {16'd0, med_sum[16]};
		med1    = EVEN ? med_adj[16:1] : med_hi;
	end

	// ---------------- update stage ----------------
	always_comb begin
		do_push  = v_s2 && s2.proceed && !alarm_q && s2.push;
		new_hot  = ($signed(s2.med) >= $signed(cfg.hot_threshold));
		old_hot  = hot_bits_q[s2.fidx][s2.slot];
		cnt_new  = hot_cnt_q[s2.fidx] - CW'(old_hot) + CW'(new_hot);
		diff     = {s2.med[15], s2.med} - {s2.oldest[15], s2.oldest};
		rise_hit = s2.rise_en && !diff[16] && (diff[15:0] >= cfg.rise_threshold);
		cnt_hit  = (CMPW'(cnt_new) >= CMPW'(cfg.hot_count_needed));
		trip     = do_push && (cnt_hit || rise_hit);
		we       = do_push;
		waddr    = AW'(32'(s2.fidx) * 32'(WINDOW) + 32'(s2.slot));
		sw_hot   = (CW'(sw_k_s1) < sm_fill_q[sw_f_s1])
		           && ($signed(rdata_q) >= $signed(cfg.hot_threshold));
	end

	always_comb begin
		res_valid             = v_s2;
		res_item.alarm        = alarm_q || trip;
		res_item.alarm_floor  = alarm_q ? alarm_src_q : (trip ? s2.floor : 3'd0);
		res_item.median_valid = do_push;
		res_item.median_value = do_push ? s2.med : 16'sd0;
	end

	// ---------------- memory ----------------
	always_ff @(posedge clk) begin
		if (we) begin
			win_mem[waddr] <= s2.med;
		end
		rdata_q    <= win_mem[raddr];
		fwd_data_q <= s2.med;
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (issue && proceed0) begin
			raw_q[fidx0][rslot0] <= in_item.temperature;
		end
		if (issue) begin
			s1.proceed <= proceed0;
			s1.push    <= push0;
			s1.fidx    <= fidx0;
			s1.floor   <= in_item.floor;
			s1.slot    <= sslot0;
			s1.rise_en <= rise0;
			s1.taps    <= taps0;
		end
		if (v_s1) begin
			s2.proceed <= s1.proceed;
			s2.push    <= s1.push;
			s2.fidx    <= s1.fidx;
			s2.floor   <= s1.floor;
			s2.slot    <= s1.slot;
			s2.rise_en <= s1.rise_en;
			s2.med     <= med1;
			s2.oldest  <= fwd_q ? fwd_data_q : rdata_q;
		end
		sw_f_s1 <= sw_f_q;
		sw_k_s1 <= sw_k_q;
	end

	// ---------------- control and per-floor state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < FLOORS; f++) begin
				raw_fill_q[f] <= '0;
				raw_slot_q[f] <= '0;
				sm_fill_q[f]  <= '0;
				sm_slot_q[f]  <= '0;
				hot_bits_q[f] <= '0;
				hot_cnt_q[f]  <= '0;
			end
			alarm_q     <= 1'b0;
			alarm_src_q <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			fwd_q       <= 1'b0;
			sw_act_q    <= 1'b0;
			sw_f_q      <= '0;
			sw_k_q      <= '0;
			sw_v_s1     <= 1'b0;
		end else begin
			v_s1    <= issue;
			v_s2    <= v_s1;
			fwd_q   <= we && (waddr == raddr) && !sw_act_q;
			sw_v_s1 <= sw_act_q;

			if (issue && proceed0) begin
				raw_slot_q[fidx0] <= (rslot0 == RSW'(N - 1)) ? '0 : rslot0 + 1'b1;
				if (rfill0 != RFW'(N)) begin
					raw_fill_q[fidx0] <= rfill0 + 1'b1;
				end
				if (push0) begin
					sm_slot_q[fidx0] <= snext0;
					if (sfill0 != CW'(WINDOW)) begin
						sm_fill_q[fidx0] <= sfill0 + 1'b1;
					end
				end
			end

			if (do_push) begin
				hot_bits_q[s2.fidx][s2.slot] <= new_hot;
				hot_cnt_q[s2.fidx]           <= cnt_new;
			end
			if (trip) begin
				alarm_q     <= 1'b1;
				alarm_src_q <= s2.floor;
			end

			// recount walks every window entry against the new threshold
			if (recount) begin
				sw_act_q <= 1'b1;
				sw_f_q   <= '0;
				sw_k_q   <= '0;
				for (int f = 0; f < FLOORS; f++) begin
					hot_cnt_q[f] <= '0;
				end
			end else if (sw_act_q) begin
				if (sw_k_q == SW'(WINDOW - 1)) begin
					sw_k_q <= '0;
					if (sw_f_q == FW'(FLOORS - 1)) begin
						sw_act_q <= 1'b0;
					end else begin
						sw_f_q <= sw_f_q + 1'b1;
					end
				end else begin
					sw_k_q <= sw_k_q + 1'b1;
				end
			end
			if (sw_v_s1) begin
				hot_bits_q[sw_f_s1][sw_k_s1] <= sw_hot;
				hot_cnt_q[sw_f_s1]           <= hot_cnt_q[sw_f_s1] + CW'(sw_hot);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/median_heat_alarm_detector.sv =====
// ----------------------------------------------------------------------------
// median_heat_alarm_detector: per-floor median heat alarm with rise check
// an accepted reading passes the input queue, median stage, update stage and result queue
// no new reading issues while the median stage holds one, keeping window writes ahead of reads
// reset clears counts and alarm; a hot_threshold write stalls issue until the recount sweep ends
// ----------------------------------------------------------------------------
`default_nettype none
module median_heat_alarm_detector import mhad_pkg::*; #(
	parameter int FLOORS      = FLOORS_DEF,
	parameter int WINDOW      = WINDOW_DEF,
	parameter int MEDIAN_TAPS = MEDIAN_TAPS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] temperature
	input  wire logic [2:0]  s_axis_tuser,   // [2:0] floor
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [0] alarm, [3:1] alarm_floor, [19:4] median_value
	output logic [0:0]       m_axis_tuser,   // [0] median_valid
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	typedef enum logic [1:0] {
		REG_HOT_THRESHOLD = 2'd0,
		REG_HOT_COUNT     = 2'd1,
		REG_RISE          = 2'd2
	} reg_idx_t;

	cfg_t            cfg_q;
	logic            recount_q;
	logic            cfg_wr;
	logic [1:0]      reg_idx;

	logic            item_valid;
	logic            item_ready;
	front_item_t     item_data;

	logic            res_valid;
	result_t         res_item;
	logic [RESULT_LW-1:0] res_level;
	logic [$bits(result_t)-1:0] out_dout;
	result_t         out_item;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hot_threshold    <= HOT_THRESHOLD_RST;
			cfg_q.hot_count_needed <= HOT_COUNT_RST;
			cfg_q.rise_threshold   <= RISE_THRESHOLD_RST;
			recount_q              <= 1'b0;
		end else begin
			recount_q <= 1'b0;
			if (cfg_wr) begin
				unique case (reg_idx)
					REG_HOT_THRESHOLD: begin
						cfg_q.hot_threshold <= pwdata[15:0];
						recount_q           <= 1'b1;
					end
					REG_HOT_COUNT: begin
						cfg_q.hot_count_needed <= pwdata[4:0];
					end
					REG_RISE: begin
						cfg_q.rise_threshold <= pwdata[15:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HOT_THRESHOLD: prdata = {16'd0, cfg_q.hot_threshold};
			REG_HOT_COUNT:     prdata = {27'd0, cfg_q.hot_count_needed};
			REG_RISE:          prdata = {16'd0, cfg_q.rise_threshold};
			default:           prdata = '0;
		endcase
	end

	mhad_front #(
		.FLOORS (FLOORS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item_data     (item_data)
	);

	mhad_back #(
		.FLOORS      (FLOORS),
		.WINDOW      (WINDOW),
		.MEDIAN_TAPS (MEDIAN_TAPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.recount   (recount_q),
		.in_valid  (item_valid),
		.in_ready  (item_ready),
		.in_item   (item_data),
		.res_valid (res_valid),
		.res_item  (res_item),
		.res_level (res_level)
	);

	// result queue: the back end only issues when a slot is free here
	mhad_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RESULT_DEPTH)
	) u_result_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (res_valid),
		.push_ready (),
		.push_data  (res_item),
		.pop_valid  (m_axis_tvalid),
		.pop_ready  (m_axis_tready),
		.pop_data   (out_dout),
		.level      (res_level)
	);

	assign out_item     = result_t'(out_dout);
	assign m_axis_tdata = {4'd0, out_item.median_value, out_item.alarm_floor, out_item.alarm};
	assign m_axis_tuser = out_item.median_valid;

endmodule
`default_nettype wire

// ===== tb/median_heat_alarm_detector_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// median_heat_alarm_detector_tb
// feeds floor-tagged temperature readings on the stream input and writes the
// threshold registers over apb while the block is idle. A scoreboard keeps its
// own per-floor raw and smoothed rings and predicts the median and the alarm
// for every reading. It then checks each result item field by field.
// ----------------------------------------------------------------------------
module median_heat_alarm_detector_tb import mhad_pkg::*;;

	localparam int FLOORS      = FLOORS_DEF;
	localparam int WIN         = WINDOW_DEF;
	localparam int TAPS        = MEDIAN_TAPS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_GAP     = 6;
	localparam int HOLD_AT     = 60;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [3:0] {
		REG_HOT_THRESHOLD  = 4'd0,
		REG_HOT_COUNT      = 4'd4,
		REG_RISE_THRESHOLD = 4'd8
	} reg_addr_t;

	typedef enum int {
		TRIP_HOT_COUNT,
		TRIP_ANY_MEDIAN,
		TRIP_ZERO_RISE,
		TRIP_RISE
	} trip_mode_t;

	class heat_alarm_scoreboard;
		int hot_limit;
		int hot_needed;
		int rise_limit;
		int raw_ring[FLOORS][TAPS];
		int raw_count[FLOORS];
		int raw_wr[FLOORS];
		int smooth_ring[FLOORS][WIN];
		int smooth_count[FLOORS];
		int smooth_wr[FLOORS];
		bit latched;
		logic [2:0] latched_floor;
		result_t expected_results[$];
		int mismatches;

		function new();
			hot_limit = HOT_THRESHOLD_RST;
			hot_needed = HOT_COUNT_RST;
			rise_limit = RISE_THRESHOLD_RST;
			latched = 1'b0;
			latched_floor = 3'd0;
			mismatches = 0;
		endfunction

		function void write_register(reg_addr_t addr, logic [31:0] value);
			case (addr)
				REG_HOT_THRESHOLD: hot_limit = $signed(value[15:0]);
				REG_HOT_COUNT: hot_needed = value[4:0];
				REG_RISE_THRESHOLD: rise_limit = value[15:0];
				default: ;
			endcase
		endfunction

		function void note_reading(logic [2:0] fl, logic signed [15:0] temp);
			result_t r;
			int sorted[TAPS];
			int key, i, j, k, hot, med;
			bit trip;
			r = '0;
			if (!latched && fl < FLOORS) begin
				raw_ring[fl][raw_wr[fl]] = temp;
				raw_wr[fl] = (raw_wr[fl] + 1) % TAPS;
				if (raw_count[fl] < TAPS)
					raw_count[fl]++;
				if (raw_count[fl] == TAPS) begin
					for (i = 0; i < TAPS; i++)
						sorted[i] = raw_ring[fl][i];
					for (i = 1; i < TAPS; i++) begin
						key = sorted[i];
						j = i - 1;
						while (j >= 0 && sorted[j] > key) begin
							sorted[j + 1] = sorted[j];
							j--;
						end
						sorted[j + 1] = key;
					end
					// even tap count takes the mean of the middle pair
					if (TAPS % 2 == 0)
						med = (sorted[TAPS / 2 - 1] + sorted[TAPS / 2]) / 2;
					else
						med = sorted[TAPS / 2];
					r.median_valid = 1'b1;
					r.median_value = 16'(med);
					smooth_ring[fl][smooth_wr[fl]] = med;
					smooth_wr[fl] = (smooth_wr[fl] + 1) % WIN;
					if (smooth_count[fl] < WIN)
						smooth_count[fl]++;
					// hot count always taken over the whole window at the current threshold
					hot = 0;
					for (k = 0; k < smooth_count[fl]; k++)
						if (smooth_ring[fl][k] >= hot_limit)
							hot++;
					trip = hot >= hot_needed;
					// once full, the write slot holds the oldest entry
					if (smooth_count[fl] == WIN && med - smooth_ring[fl][smooth_wr[fl]] >= rise_limit)
						trip = 1'b1;
					if (trip) begin
						latched = 1'b1;
						latched_floor = fl;
					end
				end
			end
			r.alarm = latched;
			r.alarm_floor = latched ? latched_floor : 3'd0;
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [23:0] data, logic [0:0] user);
			result_t want;
			if (expected_results.size() == 0) begin
				$error("result item with no reading pending: tdata %h tuser %b", data, user);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			if (data[0] !== want.alarm) begin
				$error("alarm: expected %0d, got %0d", want.alarm, data[0]);
				mismatches++;
			end
			if (data[3:1] !== want.alarm_floor) begin
				$error("alarm_floor: expected %0d, got %0d", want.alarm_floor, data[3:1]);
				mismatches++;
			end
			if (user[0] !== want.median_valid) begin
				$error("median_valid: expected %0d, got %0d", want.median_valid, user[0]);
				mismatches++;
			end
			if (data[19:4] !== want.median_value) begin
				$error("median_value: expected %0d, got %0d", want.median_value,
					$signed(data[19:4]));
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [15:0] temperature
	logic [2:0]  s_axis_tuser;   // [2:0] floor
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // [0] alarm, [3:1] alarm_floor, [19:4] median_value
	logic [0:0]  m_axis_tuser;   // [0] median_valid
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	heat_alarm_scoreboard sb = new();
	int readings_sent = 0;
	int results_seen = 0;
	int cycles = 0;
	int lo_seen, hi_seen;

	median_heat_alarm_detector dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_reading(input logic [2:0] fl, input logic signed [15:0] temp);
		int gap;
		gap = (readings_sent % 80 < 15) ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= temp;
		s_axis_tuser <= fl;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		sb.note_reading(fl, temp);
		readings_sent++;
	endtask

	// mostly valid floors, some out of range
	task automatic send_random(input int lo, input int hi);
		logic [2:0] fl;
		if ($urandom_range(0, 9) == 0)
			fl = 3'($urandom_range(FLOORS, 7));
		else
			fl = 3'($urandom_range(0, FLOORS - 1));
		send_reading(fl, 16'(lo + int'($urandom_range(0, hi - lo))));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input reg_addr_t addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_register(addr, value);
	endtask

	// threshold goes last since it starts a recount inside the block
	task automatic configure(input int hot_thr, input int hot_cnt, input int rise_thr);
		wait_drained();
		apb_write(REG_HOT_COUNT, hot_cnt);
		apb_write(REG_RISE_THRESHOLD, rise_thr);
		apb_write(REG_HOT_THRESHOLD, hot_thr);
	endtask

	// result side: random stalls, one long hold-off while the input keeps coming
	initial begin
		int gap;
		logic [23:0] got_data;
		logic [0:0] got_user;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_seen == HOLD_AT)
				gap = HOLD_CYCLES;
			else if (results_seen % 70 < 12)
				gap = 0;
			else
				gap = $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(negedge clk); while (!m_axis_tvalid);
			got_data = m_axis_tdata;
			got_user = m_axis_tuser;
			@(posedge clk);
			sb.check_result(got_data, got_user);
			results_seen++;
		end
	end

	initial begin
		int thr, lo, hi, rise, tail, n;
		trip_mode_t mode;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset thresholds: out-of-range floors, extremes, ring fill, hot boundary
		send_reading(3'd7, 16'h8000);
		send_reading(3'd5, 16'h7fff);
		send_reading(3'd6, 16'h0000);
		send_reading(3'd0, 16'h8000);
		send_reading(3'd0, 16'h7fff);
		send_reading(3'd0, 16'h0000);
		send_reading(3'd0, 16'hffff);
		send_reading(3'd0, 16'h0001);
		send_reading(3'd0, 16'h7fff);
		send_reading(3'd0, 16'h7fff);
		for (int i = 0; i < TAPS; i++)
			send_reading(3'd4, 16'(100 - 10 * i));
		for (int i = 0; i < TAPS; i++)
			send_reading(3'd1, 16'sd58);
		send_reading(3'd2, -16'sd5);
		send_reading(3'd3, 16'sd57);

		// each band contains every earlier value: medians stay below the hot
		// threshold and no swing reaches the rise threshold
		lo_seen = -100;
		hi_seen = 100;
		for (int p = 0; p < 2; p++) begin
			thr = hi_seen + 1 + int'($urandom_range(0, 12000));
			if (thr > 32767)
				thr = 32767;
			lo = lo_seen - int'($urandom_range(0, 12000));
			if (lo < -32768)
				lo = -32768;
			rise = $urandom_range(thr - lo, 65535);
			configure(thr, (p == 0) ? 1 : int'($urandom_range(1, WIN)), rise);
			repeat (100) send_random(lo, thr - 1);
			hi_seen = thr - 1;
			lo_seen = lo;
		end

		// full range readings under the strictest settings
		configure(32767, WIN, 65535);
		repeat (150) send_random(-32768, 32767);

		// let the alarm latch one way or another, then check it holds
		mode = trip_mode_t'($urandom_range(0, 3));
		lo = -32768;
		hi = 32767;
		case (mode)
			TRIP_HOT_COUNT: begin
				thr = int'($urandom_range(0, 40000)) - 20000;
				configure(thr, $urandom_range(1, WIN), 65535);
				lo = thr;
				hi = thr + 500;
			end
			TRIP_ANY_MEDIAN: configure(-32768, 0, 65535);
			TRIP_ZERO_RISE: configure(32767, WIN, 0);
			default: configure(32767, WIN,
				$urandom_range(0, 1) ? 1 : int'($urandom_range(1, 40000)));
		endcase
		tail = 0;
		for (n = 0; n < 200 && tail < 20; n++) begin
			send_random(lo, hi);
			if (sb.latched)
				tail++;
		end

		wait_drained();
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mhad_pkg.sv
rtl/mhad_fifo.sv
rtl/mhad_front.sv
rtl/mhad_back.sv
rtl/median_heat_alarm_detector.sv
tb/median_heat_alarm_detector_tb.sv
